/* sv/unwind_opcode_decoder_defines.svh */
// assertion macros for the unwind opcode decoder
// used by the top level, expects clk and rst in scope
`ifndef UNWIND_OPCODE_DECODER_DEFINES_SVH
`define UNWIND_OPCODE_DECODER_DEFINES_SVH

// same-cycle implication
`define UOD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UOD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/uod_pkg.sv */
// shared types and codes for the unwind opcode decoder
// used by uod_decode and unwind_opcode_decoder
package uod_pkg;

  localparam logic [3:0] CMD_FINISH    = 4'd0;
  localparam logic [3:0] CMD_DATA_POP  = 4'd1;
  localparam logic [3:0] CMD_DATA_PUSH = 4'd2;
  localparam logic [3:0] CMD_REG_POP   = 4'd3;
  localparam logic [3:0] CMD_REG_TO_SP = 4'd4;
  localparam logic [3:0] CMD_VFP_POP   = 4'd5;
  localparam logic [3:0] CMD_WREG_POP  = 4'd6;
  localparam logic [3:0] CMD_WCGR_POP  = 4'd7;
  localparam logic [3:0] CMD_REFUSED   = 4'd8;
  localparam logic [3:0] CMD_RESERVED  = 4'd9;
  localparam logic [3:0] CMD_TRUNCATED = 4'd10;

  localparam logic [2:0] PK_NONE    = 3'd0;
  localparam logic [2:0] PK_REGMASK = 3'd1;
  localparam logic [2:0] PK_LOWREGS = 3'd2;
  localparam logic [2:0] PK_ULEB    = 3'd3;
  localparam logic [2:0] PK_VFP     = 3'd4;
  localparam logic [2:0] PK_WREG    = 3'd5;
  localparam logic [2:0] PK_WCGR    = 3'd6;

  typedef struct packed {
    logic [2:0]  pending_kind;
    logic [7:0]  first_byte;
    logic [31:0] uleb_accumulator;
    logic [5:0]  uleb_shift;
    logic        halted;
  } uod_state_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] data_word;
    logic        vfp_double;
    logic        vfp_shift_sixteen;
    logic        sequence_stop;
  } uod_result_t;

endpackage

/* sv/uod_decode.sv */
// per-byte decode: parser state and one opcode byte in, next state and result out
// depends on uod_pkg
module uod_decode (
  input  uod_pkg::uod_state_t  state,
  input  logic [7:0]           opcode_byte,
  input  logic                 sequence_end,
  output uod_pkg::uod_state_t  state_next,
  output logic                 res_valid,
  output uod_pkg::uod_result_t res
);
  import uod_pkg::*;

  logic [2:0]  start_kind;
  logic [3:0]  cmd;
  logic [31:0] data;
  logic        dbl;
  logic        s16;
  logic        stop;
  logic [7:0]  low_mask;
  logic [31:0] uleb_shifted;
  logic [31:0] uleb_acc_upd;
  logic [5:0]  uleb_shift_upd;
  logic [8:0]  pop_bytes;

  assign low_mask  = 8'(~(8'hff << ({1'b0, opcode_byte[2:0]} + 4'd1)));
  assign pop_bytes = {1'b0, opcode_byte[5:0], 2'b00} + 9'd4;

  // ulеb group lands only while the shift is below 32
  assign uleb_shifted   = {25'b0, opcode_byte[6:0]} << state.uleb_shift[4:0];
  assign uleb_acc_upd   = state.uleb_shift[5] ? state.uleb_accumulator
                                              : (state.uleb_accumulator | uleb_shifted);
  assign uleb_shift_upd = state.uleb_shift[5] ? state.uleb_shift
                                              : (state.uleb_shift + 6'd7);

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    start_kind = PK_NONE;
    cmd        = CMD_RESERVED;
    data       = '0;
    dbl        = 1'b0;
    s16        = 1'b0;
    if (state.halted) begin
      res_valid = 1'b0;
    end else if (state.pending_kind == PK_NONE) begin
      case (opcode_byte) inside
        [8'h00:8'h3f]: begin
          cmd  = CMD_DATA_POP;
          data = {23'b0, pop_bytes};
        end
        [8'h40:8'h7f]: begin
          cmd  = CMD_DATA_PUSH;
          data = {23'b0, pop_bytes};
        end
        [8'h80:8'h8f]: start_kind = PK_REGMASK;
        8'h9d, 8'h9f:  cmd = CMD_RESERVED;
        [8'h90:8'h9f]: begin
          cmd  = CMD_REG_TO_SP;
          data = {28'b0, opcode_byte[3:0]};
        end
        [8'ha0:8'haf]: begin
          cmd  = CMD_REG_POP;
          data = {17'b0, opcode_byte[3], 2'b00, low_mask, 4'b0000};
        end
        8'hb0: cmd = CMD_FINISH;
        8'hb1: start_kind = PK_LOWREGS;
        8'hb2: start_kind = PK_ULEB;
        8'hb3, 8'hc8, 8'hc9: start_kind = PK_VFP;
        [8'hb8:8'hbf], [8'hd0:8'hd7]: begin
          cmd  = CMD_VFP_POP;
          data = {24'b0, 5'b10000, opcode_byte[2:0]};
          dbl  = (opcode_byte[7:3] == 5'b11010);
        end
        [8'hc0:8'hc5]: begin
          cmd  = CMD_WREG_POP;
          data = {24'b0, 5'b10100, opcode_byte[2:0]};
        end
        8'hc6: start_kind = PK_WREG;
        8'hc7: start_kind = PK_WCGR;
        default: cmd = CMD_RESERVED;
      endcase
      if (start_kind != PK_NONE) begin
        state_next.pending_kind     = start_kind;
        state_next.first_byte       = opcode_byte;
        state_next.uleb_accumulator = '0;
        state_next.uleb_shift       = '0;
        if (sequence_end) begin
          res_valid = 1'b1;
          cmd       = CMD_TRUNCATED;
          data      = {24'b0, opcode_byte};
        end
      end else begin
        res_valid = 1'b1;
      end
    end else begin
      res_valid               = 1'b1;
      state_next.pending_kind = PK_NONE;
      case (state.pending_kind)
        PK_REGMASK: begin
          if (state.first_byte == 8'h80 && opcode_byte == 8'h00) begin
            cmd = CMD_REFUSED;
          end else begin
            cmd  = CMD_REG_POP;
            data = {16'b0, state.first_byte[3:0], opcode_byte, 4'b0000};
          end
        end
        PK_LOWREGS, PK_WCGR: begin
          if (opcode_byte != 8'h00 && opcode_byte[7:4] == 4'h0) begin
            cmd  = (state.pending_kind == PK_LOWREGS) ? CMD_REG_POP : CMD_WCGR_POP;
            data = {28'b0, opcode_byte[3:0]};
          end
        end
        PK_ULEB: begin
          state_next.uleb_accumulator = uleb_acc_upd;
          state_next.uleb_shift       = uleb_shift_upd;
          if (opcode_byte[7]) begin
            state_next.pending_kind = PK_ULEB;
            res_valid               = sequence_end;
            cmd                     = CMD_TRUNCATED;
            data                    = {24'b0, state.first_byte};
          end else begin
            cmd  = CMD_DATA_POP;
            data = {uleb_acc_upd[29:0], 2'b00} + 32'h0000_0204;
          end
        end
        PK_VFP: begin
          cmd  = CMD_VFP_POP;
          data = {24'b0, opcode_byte};
          s16  = (state.first_byte == 8'hc8);
          dbl  = (state.first_byte != 8'hb3);
        end
        PK_WREG: begin
          cmd  = CMD_WREG_POP;
          data = {24'b0, opcode_byte};
        end
        default: cmd = CMD_RESERVED;
      endcase
    end
    stop = sequence_end || cmd == CMD_FINISH || cmd == CMD_REFUSED
        || cmd == CMD_RESERVED || cmd == CMD_TRUNCATED;
    if (sequence_end) begin
      state_next = '0;
    end else if (res_valid && stop) begin
      state_next.halted = 1'b1;
    end
  end

  assign res = '{command: cmd, data_word: data, vfp_double: dbl,
                 vfp_shift_sixteen: s16, sequence_stop: stop};

endmodule

/* sv/unwind_opcode_decoder.sv */
// top level of the unwind opcode decoder: input register, decode, result register
// depends on uod_pkg, uod_decode and unwind_opcode_decoder_defines.svh
//
//  channel  | direction | tdata              | tuser                          | tlast
//  s_*      | in        | [7:0] opcode_byte  | -                              | sequence_end
//  m_*      | out       | [31:0] data_word   | [3:0] command, [4] vfp_double, | sequence_stop
//           |           |                    | [5] vfp_shift_sixteen          |
//
// one byte per cycle unless a result stalls; results pass the input then the result register
// the rate is set by the byte-to-byte parser state, which uod_decode updates per accepted byte
// bytes that give no result never wait on m_tready
// while a result stalls, the next result byte waits in the input register and s_tready drops
// rst synchronously clears parser state and both valid flags
`include "unwind_opcode_decoder_defines.svh"

module unwind_opcode_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] opcode_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] data_word
  output logic [7:0]  m_tuser,   // [3:0] command, [4] vfp_double, [5] vfp_shift_sixteen
  output logic        m_tlast
);
  import uod_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  uod_result_t out_res;
  uod_state_t  st;
  uod_state_t  st_next;
  logic        res_valid;
  uod_result_t res;
  logic        advance;

  uod_decode u_decode (
    .state        (st),
    .opcode_byte  (in_byte),
    .sequence_end (in_last),
    .state_next   (st_next),
    .res_valid    (res_valid),
    .res          (res)
  );

  assign advance  = in_valid && (!res_valid || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        st <= st_next;
      end
      if (advance && res_valid) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res.data_word;
  assign m_tuser  = {2'b00, out_res.vfp_shift_sixteen, out_res.vfp_double, out_res.command};
  assign m_tlast  = out_res.sequence_stop;

  `UOD_ASSERT_NOW(a_stop_cmds, m_tvalid && (out_res.command == CMD_FINISH || out_res.command == CMD_REFUSED || out_res.command == CMD_RESERVED || out_res.command == CMD_TRUNCATED), m_tlast, "terminating command without sequence_stop")
  `UOD_ASSERT_NOW(a_vfp_flags, m_tvalid && out_res.command != CMD_VFP_POP, !out_res.vfp_double && !out_res.vfp_shift_sixteen, "vfp flag set on non vfp command")
  `UOD_ASSERT_NOW(a_halt_idle, st.halted, st.pending_kind == PK_NONE, "halted with an opcode pending")
  `UOD_ASSERT_NOW(a_uleb_shift, 1'b1, st.uleb_shift <= 6'd35, "uleb shift out of range")
  `UOD_ASSERT_NEXT(a_end_clears, advance && in_last, st == '0, "parser state not cleared after sequence end")

endmodule
